// ===== hw/rtl/tc_pkg.sv =====
// tc_pkg: shared types, constants and the coefficient function
// for the thermocouple converter; no dependencies
`timescale 1ns / 1ps

package tc_pkg;

   localparam int ADC_BITS = 12;
   localparam int CHANNELS = 4;
   localparam int NUM_CAL = 4;
   localparam int RAW_W = 12;
   localparam int CJ_W = 15;
   localparam int CH_W = 2;
   localparam int TEMP_W = 11;
   localparam int GAIN_W = 15;
   localparam int OFS_W = 16;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 16;
   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 16;
   localparam int X_W = 32;
   localparam int ACC_W = 48;

   localparam logic [29:0] MV_RAW_K = 30'd738365276;
   localparam logic [27:0] MV_OFS_K = 28'd176616974;
   // cold junction: floor((cj*2^24+125)/250) = cj*67108 + floor((cj*108+62)/125)
   localparam logic [16:0] CJ_INT_K = 17'd67108;
   localparam int CJ_BIAS = 62 + 125 * 16384;
   localparam logic [22:0] RECIP_125 = 23'd4294968;
   localparam logic signed [ACC_W-1:0] ACC_LIM = 48'sd70368744177664;

   localparam logic [TEMP_W-1:0] TEMP_INVALID = '1;

   typedef struct packed {
      logic valid;
      logic bad;
      logic [CH_W-1:0] ch;
      logic signed [X_W-1:0] x;
      logic signed [ACC_W-1:0] acc;
   } tc_item_type;

   // round-half-up(mant * 2^(5*deg+16) / 10^dexp), signed by table
   function automatic logic signed [ACC_W-1:0] coef_value(input int pos_set, input int deg);
      logic [31:0] mant;
      int dexp;
      logic neg;
      logic [127:0] num;
      logic [63:0] den;
      logic [63:0] r;
      logic [63:0] q;
      int i;
      mant = 32'd0;
      dexp = 0;
      neg = 1'b0;
      if (pos_set != 0) begin
         case (deg)
            1: begin mant = 32'd2508355; dexp = 5; neg = 1'b0; end
            2: begin mant = 32'd7860106; dexp = 8; neg = 1'b0; end
            3: begin mant = 32'd2503131; dexp = 7; neg = 1'b1; end
            4: begin mant = 32'd8315270; dexp = 8; neg = 1'b0; end
            5: begin mant = 32'd1228034; dexp = 8; neg = 1'b1; end
            6: begin mant = 32'd9804036; dexp = 10; neg = 1'b0; end
            7: begin mant = 32'd4413030; dexp = 11; neg = 1'b1; end
            8: begin mant = 32'd1057734; dexp = 12; neg = 1'b0; end
            9: begin mant = 32'd1052755; dexp = 14; neg = 1'b1; end
            default: begin mant = 32'd0; dexp = 0; neg = 1'b0; end
         endcase
      end else begin
         case (deg)
            1: begin mant = 32'd25173462; dexp = 6; neg = 1'b0; end
            2: begin mant = 32'd11662878; dexp = 7; neg = 1'b1; end
            3: begin mant = 32'd10833638; dexp = 7; neg = 1'b1; end
            4: begin mant = 32'd89773540; dexp = 8; neg = 1'b1; end
            5: begin mant = 32'd37342377; dexp = 8; neg = 1'b1; end
            6: begin mant = 32'd86632643; dexp = 9; neg = 1'b1; end
            7: begin mant = 32'd10450598; dexp = 9; neg = 1'b1; end
            8: begin mant = 32'd51920577; dexp = 11; neg = 1'b1; end
            default: begin mant = 32'd0; dexp = 0; neg = 1'b0; end
         endcase
      end
      den = 64'd1;
      for (i = 0; i < dexp; i++) begin
         den = den * 64'd10;
      end
      num = 128'(mant) << (5 * deg + 16);
      q = 64'd0;
      r = 64'd0;
      for (i = 127; i >= 0; i--) begin
         r = {r[62:0], num[i]};
         q = {q[62:0], 1'b0};
         if (r >= den) begin
            r = r - den;
            q[0] = 1'b1;
         end
      end
      if ({r[62:0], 1'b0} >= den) begin
         q = q + 64'd1;
      end
      return neg ? -$signed(q[ACC_W-1:0]) : $signed(q[ACC_W-1:0]);
   endfunction

endpackage

// ===== hw/rtl/tc_front.sv =====
// tc_front: code and cold-junction voltage to millivolts in Q6.26, two stages
// depends on tc_pkg
`timescale 1ns / 1ps

module tc_front
   import tc_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  logic en,
   input  logic in_valid,
   input  logic [CH_W-1:0] in_ch,
   input  logic [RAW_W-1:0] in_raw,
   input  logic signed [CJ_W-1:0] in_cj,
   output tc_item_type out_item
);

   localparam logic signed [ACC_W-1:0] COEF9_P = coef_value(1, 9);
   localparam logic signed [ACC_W-1:0] COEF9_N = coef_value(0, 9);

   logic valid_ff;
   logic bad_ff;
   logic [CH_W-1:0] ch_ff;
   logic [41:0] raw_prod_ff;
   logic signed [32:0] cj_int_ff;
   logic [44:0] cj_frac_ff;
   tc_item_type item_ff;

   logic signed [22:0] cj_lin;
   logic [21:0] cj_pos;
   logic [41:0] raw_prod_in;
   logic signed [32:0] cj_int_in;
   logic [44:0] cj_frac_in;
   logic signed [33:0] x_sum;
   tc_item_type item_in;

   always_comb begin
      // cj*108 by shift and add
      cj_lin = (23'(in_cj) <<< 6) + (23'(in_cj) <<< 5) + (23'(in_cj) <<< 3)
             + (23'(in_cj) <<< 2) + 23'(CJ_BIAS);
      cj_pos = cj_lin[21:0];
      raw_prod_in = 42'(in_raw) * 42'(MV_RAW_K);
      cj_int_in = 33'(in_cj) * $signed({16'd0, CJ_INT_K});
      cj_frac_in = 45'(cj_pos) * 45'(RECIP_125);

      x_sum = $signed({1'b0, 33'((raw_prod_ff + 42'(1 << (ADC_BITS - 1))) >> ADC_BITS)})
            - $signed({6'd0, MV_OFS_K})
            + 34'(cj_int_ff)
            + $signed({18'd0, cj_frac_ff[44:29]}) - 34'sd16384;
      item_in.valid = valid_ff;
      item_in.bad = bad_ff;
      item_in.ch = ch_ff;
      item_in.x = x_sum[X_W-1:0];
      item_in.acc = x_sum[X_W-1] ? COEF9_N : COEF9_P;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         item_ff.valid <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
         item_ff.valid <= item_in.valid;
      end
      if (en) begin
         bad_ff <= (32'(in_ch) >= 32'(CHANNELS));
         ch_ff <= in_ch;
         raw_prod_ff <= raw_prod_in;
         cj_int_ff <= cj_int_in;
         cj_frac_ff <= cj_frac_in;
         item_ff.bad <= item_in.bad;
         item_ff.ch <= item_in.ch;
         item_ff.x <= item_in.x;
         item_ff.acc <= item_in.acc;
      end
   end

   assign out_item = item_ff;

endmodule

// ===== hw/rtl/tc_horner_step.sv =====
// tc_horner_step: one Horner step acc = floor(acc*x/2^31) + c_deg, clamped;
// a split multiply stage and a sum stage; depends on tc_pkg
`timescale 1ns / 1ps

module tc_horner_step
   import tc_pkg::*;
#(
   parameter int DEG = 0
) (
   input  logic clock,
   input  logic reset,
   input  logic en,
   input  tc_item_type in_item,
   output tc_item_type out_item
);

   localparam logic signed [ACC_W-1:0] COEF_P = coef_value(1, DEG);
   localparam logic signed [ACC_W-1:0] COEF_N = coef_value(0, DEG);

   logic valid_ff;
   logic bad_ff;
   logic [CH_W-1:0] ch_ff;
   logic signed [X_W-1:0] x_ff;
   logic signed [55:0] p_hi_ff;
   logic signed [56:0] p_lo_ff;
   tc_item_type item_ff;

   logic signed [55:0] p_hi_in;
   logic signed [56:0] p_lo_in;
   logic signed [79:0] prod;
   logic signed [79:0] prod_sh;
   logic signed [ACC_W:0] acc_sum;
   tc_item_type item_in;

   always_comb begin
      p_hi_in = $signed(in_item.acc[ACC_W-1:24]) * in_item.x;
      p_lo_in = $signed({1'b0, in_item.acc[23:0]}) * in_item.x;
      prod = (80'(p_hi_ff) <<< 24) + 80'(p_lo_ff);
      prod_sh = prod >>> 31;
      acc_sum = prod_sh[ACC_W:0] + (x_ff[X_W-1] ? (ACC_W+1)'(COEF_N) : (ACC_W+1)'(COEF_P));
      item_in.valid = valid_ff;
      item_in.bad = bad_ff;
      item_in.ch = ch_ff;
      item_in.x = x_ff;
      if (acc_sum > (ACC_W+1)'(ACC_LIM)) begin
         item_in.acc = ACC_LIM;
      end else if (acc_sum < -(ACC_W+1)'(ACC_LIM)) begin
         item_in.acc = -ACC_LIM;
      end else begin
         item_in.acc = acc_sum[ACC_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         item_ff.valid <= 1'b0;
      end else if (en) begin
         valid_ff <= in_item.valid;
         item_ff.valid <= item_in.valid;
      end
      if (en) begin
         bad_ff <= in_item.bad;
         ch_ff <= in_item.ch;
         x_ff <= in_item.x;
         p_hi_ff <= p_hi_in;
         p_lo_ff <= p_lo_in;
         item_ff.bad <= item_in.bad;
         item_ff.ch <= item_in.ch;
         item_ff.x <= item_in.x;
         item_ff.acc <= item_in.acc;
      end
   end

   assign out_item = item_ff;

endmodule

// ===== hw/rtl/tc_calib.sv =====
// tc_calib: truncation to degrees, channel gain and offset, saturation;
// three stages, the last is the output register; depends on tc_pkg
`timescale 1ns / 1ps

module tc_calib
   import tc_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  logic en,
   input  tc_item_type in_item,
   input  logic [GAIN_W-1:0] gain [NUM_CAL],
   input  logic signed [OFS_W-1:0] offset [NUM_CAL],
   output logic out_valid,
   output logic signed [TEMP_W-1:0] out_temp
);

   logic t_valid_ff;
   logic t_bad_ff;
   logic signed [15:0] t_ff;
   logic [GAIN_W-1:0] gain_ff;
   logic signed [OFS_W-1:0] ofs_ff;
   logic v_valid_ff;
   logic v_bad_ff;
   logic signed [32:0] v_ff;
   logic o_valid_ff;
   logic signed [TEMP_W-1:0] o_temp_ff;

   logic signed [ACC_W-1:0] acc_rnd;
   logic signed [31:0] t_full;
   logic signed [15:0] t_in;
   logic signed [32:0] v_in;
   logic signed [32:0] v_rnd;
   logic signed [18:0] adj;
   logic signed [TEMP_W-1:0] temp_in;

   always_comb begin
      // truncate toward zero
      acc_rnd = in_item.acc + (in_item.acc[ACC_W-1] ? ACC_W'(65535) : '0);
      t_full = 32'(acc_rnd >>> 16);
      if (t_full > 32'sd32767) begin
         t_in = 16'sh7FFF;
      end else if (t_full < -32'sd32768) begin
         t_in = -16'sd32768;
      end else begin
         t_in = t_full[15:0];
      end

      v_in = 33'(t_ff) * $signed({18'd0, gain_ff}) - (33'(ofs_ff) <<< 6);

      v_rnd = v_ff + (v_ff[32] ? 33'sd16383 : 33'sd0);
      adj = 19'(v_rnd >>> 14);
      if (v_bad_ff) begin
         temp_in = TEMP_INVALID;
      end else if (adj > 19'sd1023) begin
         temp_in = 11'sd1023;
      end else if (adj < -19'sd1023) begin
         temp_in = -11'sd1023;
      end else begin
         temp_in = adj[TEMP_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         t_valid_ff <= 1'b0;
         v_valid_ff <= 1'b0;
         o_valid_ff <= 1'b0;
      end else if (en) begin
         t_valid_ff <= in_item.valid;
         v_valid_ff <= t_valid_ff;
         o_valid_ff <= v_valid_ff;
      end
      if (en) begin
         t_bad_ff <= in_item.bad;
         t_ff <= t_in;
         gain_ff <= gain[in_item.ch];
         ofs_ff <= offset[in_item.ch];
         v_bad_ff <= t_bad_ff;
         v_ff <= v_in;
         o_temp_ff <= temp_in;
      end
   end

   assign out_valid = o_valid_ff;
   assign out_temp = o_temp_ff;

endmodule

// ===== hw/rtl/thermocouple_temperature_convert.sv =====
// thermocouple_temperature_convert: top level, calibration registers and the
// pipeline of front end, nine Horner steps and calibration; depends on tc_pkg
//
// Usage: a request word carries channel, ADC code and cold-junction microvolts
// on req_tdata; one response word with the calibrated temperature in whole
// degrees comes back on rsp_tdata for each request, in order. A channel with
// no calibration unit answers -1.
// Calibration registers are written through csr_we/csr_index/csr_wdata while
// no word is in flight; index 2k is the channel k gain, 2k+1 its offset.
// From request to response a word passes 2 front-end stages, 2 per Horner
// step for 9 steps (split multiply, then sum and clamp) and 3
// calibration stages, the last being the output register.
// Throughput is one word per cycle; a new request is taken every cycle while
// the response side is not stalled.
// When rsp_tready is low with a response pending, the whole pipeline holds and
// req_tready drops; nothing is lost or repeated.
// Synchronous reset empties the pipeline and loads the calibration defaults.
`timescale 1ns / 1ps

module thermocouple_temperature_convert
   import tc_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // channel[1:0], raw_sample[13:2], cold_junction_uv[28:14]
   output logic rsp_tvalid,
   input  logic rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,  // temperature_c[10:0]
   input  logic csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int STEPS = 9;

   logic [GAIN_W-1:0] gain_ff [NUM_CAL];
   logic signed [OFS_W-1:0] offset_ff [NUM_CAL];
   logic en;
   tc_item_type items [STEPS+1];
   logic signed [TEMP_W-1:0] temp;

   assign en = !rsp_tvalid || rsp_tready;
   assign req_tready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff[0] <= 15'd16483;
         offset_ff[0] <= 16'sd792;
         gain_ff[1] <= 15'd16483;
         offset_ff[1] <= 16'sd536;
         gain_ff[2] <= 15'd16583;
         offset_ff[2] <= 16'sd435;
         gain_ff[3] <= 15'd16384;
         offset_ff[3] <= 16'sd0;
      end else if (csr_we) begin
         if (csr_index[0]) begin
            offset_ff[csr_index[CSR_IDX_W-1:1]] <= $signed(csr_wdata[OFS_W-1:0]);
         end else begin
            gain_ff[csr_index[CSR_IDX_W-1:1]] <= csr_wdata[GAIN_W-1:0];
         end
      end
   end

   tc_front u_front (
      .clock(clock),
      .reset(reset),
      .en(en),
      .in_valid(req_tvalid),
      .in_ch(req_tdata[1:0]),
      .in_raw(req_tdata[13:2]),
      .in_cj($signed(req_tdata[28:14])),
      .out_item(items[0])
   );

   for (genvar k = 0; k < STEPS; k++) begin : g_step
      tc_horner_step #(
         .DEG(STEPS - 1 - k)
      ) u_step (
         .clock(clock),
         .reset(reset),
         .en(en),
         .in_item(items[k]),
         .out_item(items[k+1])
      );
   end

   tc_calib u_calib (
      .clock(clock),
      .reset(reset),
      .en(en),
      .in_item(items[STEPS]),
      .gain(gain_ff),
      .offset(offset_ff),
      .out_valid(rsp_tvalid),
      .out_temp(temp)
   );

   assign rsp_tdata = {{(RSP_DATA_W-TEMP_W){1'b0}}, temp};

endmodule

// ===== verif/tb_thermocouple_temperature_convert.sv =====
// tb_thermocouple_temperature_convert: checks the type K converter by
// predicting every temperature word from the calibration registers.
// Depends on tc_pkg and thermocouple_temperature_convert.
`timescale 1ns / 1ps

module tb_thermocouple_temperature_convert;
   import tc_pkg::*;

   typedef struct packed {
      logic [CH_W-1:0] ch;
      logic [RAW_W-1:0] raw;
      logic signed [CJ_W-1:0] cj;
   } sample_type;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int SETTLE_CYCLES = 40;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;  // channel, raw_sample, cold_junction_uv
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;       // temperature_c
   logic csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   sample_type pending_samples[$];
   logic signed [TEMP_W-1:0] expected_temps[$];
   logic [GAIN_W-1:0] cal_gain[NUM_CAL];
   logic signed [OFS_W-1:0] cal_ofs[NUM_CAL];
   logic signed [63:0] poly_coef[2][10];
   logic idle_enable = 1'b1;
   int req_gap = 0;
   int rsp_gap = 0;
   int quiet_cycles = 0;
   int fail_count = 0;

   thermocouple_temperature_convert DUT (.*);

   always #10 clock = ~clock;

   function automatic longint floor_div(longint n, longint d);
      if (n >= 0) return n / d;
      return -((-n + d - 1) / d);
   endfunction

   // coefficient n scaled by 32^n in Q16, rounded half up in magnitude
   function automatic logic signed [63:0] scale_coef(int mant, int dexp, bit neg, int deg);
      logic [127:0] num;
      logic [127:0] den;
      logic [127:0] q;
      logic [127:0] r;
      den = 1;
      for (int i = 0; i < dexp; i++) den = den * 10;
      num = 128'(mant) << (5 * deg + 16);
      q = num / den;
      r = num % den;
      if (2 * r >= den) q = q + 1;
      return neg ? -$signed(q[63:0]) : $signed(q[63:0]);
   endfunction

   function automatic logic signed [TEMP_W-1:0] predict_temp(sample_type s);
      longint mv_q26;
      longint acc;
      longint deg_c;
      longint v;
      int sel;
      logic signed [127:0] prod;
      logic signed [127:0] a_w;
      logic signed [127:0] x_w;
      mv_q26 = ((longint'(s.raw) * longint'(MV_RAW_K) + 2048) >>> 12) - longint'(MV_OFS_K)
               + floor_div(longint'(s.cj) * 16777216 + 125, 250);
      sel = (mv_q26 >= 0) ? 1 : 0;
      acc = poly_coef[sel][9];
      for (int n = 8; n >= 0; n--) begin
         a_w = acc;
         x_w = mv_q26;
         prod = a_w * x_w;
         acc = longint'(prod >>> 31) + poly_coef[sel][n];
         if (acc > (64'sd1 <<< 46)) acc = 64'sd1 <<< 46;
         if (acc < -(64'sd1 <<< 46)) acc = -(64'sd1 <<< 46);
      end
      deg_c = acc / 65536;
      if (deg_c > 32767) deg_c = 32767;
      if (deg_c < -32768) deg_c = -32768;
      v = deg_c * longint'(cal_gain[s.ch]) - longint'(cal_ofs[s.ch]) * 64;
      v = v / 16384;
      if (v > 1023) v = 1023;
      if (v < -1023) v = -1023;
      return TEMP_W'(v);
   endfunction

   // driver
   always @(posedge clock) begin
      sample_type s;
      logic next_valid;
      next_valid = req_tvalid;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            s = pending_samples.pop_front();
            expected_temps.push_back(predict_temp(s));
            next_valid = 1'b0;
         end
         if (!next_valid) begin
            if (req_gap > 0) begin
               req_gap--;
            end else if (pending_samples.size() > 0) begin
               s = pending_samples[0];
               req_tdata <= {3'b0, s.cj, s.raw, s.ch};
               next_valid = 1'b1;
               if (idle_enable && $urandom_range(0, 5) == 0) req_gap = $urandom_range(1, 9);
            end
         end
      end
      req_tvalid <= next_valid;
   end

   // monitor
   always @(posedge clock) begin
      logic signed [TEMP_W-1:0] want;
      logic signed [TEMP_W-1:0] got;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[TEMP_W-1:0];
            if (expected_temps.size() == 0) begin
               $error("temperature_c: no word expected, actual %0d", got);
               fail_count++;
            end else begin
               want = expected_temps.pop_front();
               if (got !== want) begin
                  $error("temperature_c: expected %0d, actual %0d", want, got);
                  fail_count++;
               end
            end
         end
         if (rsp_gap > 0) begin
            rsp_gap--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            if (idle_enable && $urandom_range(0, 5) == 0) rsp_gap = $urandom_range(1, 9);
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || reset || csr_we) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic wait_drained();
      wait (pending_samples.size() == 0 && expected_temps.size() == 0 && !req_tvalid);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(int idx, int value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= CSR_IDX_W'(idx);
      csr_wdata <= CSR_DATA_W'(value);
      if (idx % 2 == 0) cal_gain[idx / 2] = GAIN_W'(value);
      else cal_ofs[idx / 2] = OFS_W'(value);
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic add_sample(int ch, int raw, int cj);
      sample_type s;
      s.ch = CH_W'(ch);
      s.raw = RAW_W'(raw);
      s.cj = CJ_W'(cj);
      pending_samples.push_back(s);
   endtask

   task automatic add_random(int count);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 3) == 0)
            add_sample($urandom_range(0, 3), $urandom_range(0, 4095), $urandom_range(0, 32767));
         else
            add_sample($urandom_range(0, 3), $urandom_range(0, 4095),
                       int'($urandom_range(0, 20000)) - 10000);
      end
   endtask

   initial begin
      static int mant[2][10] = '{
         '{0, 25173462, 11662878, 10833638, 89773540, 37342377, 86632643, 10450598, 51920577, 0},
         '{0, 2508355, 7860106, 2503131, 8315270, 1228034, 9804036, 4413030, 1057734, 1052755}};
      static int dexp[2][10] = '{'{0, 6, 7, 7, 8, 8, 9, 9, 11, 0},
                                 '{0, 5, 8, 7, 8, 8, 10, 11, 12, 14}};
      static bit neg[2][10] = '{'{0, 0, 1, 1, 1, 1, 1, 1, 1, 0},
                                '{0, 0, 0, 1, 0, 1, 0, 1, 0, 1}};
      for (int s = 0; s < 2; s++)
         for (int n = 0; n < 10; n++)
            poly_coef[s][n] = scale_coef(mant[s][n], dexp[s][n], neg[s][n], n);
      cal_gain = '{16483, 16483, 16583, 16384};
      cal_ofs = '{792, 536, 435, 0};

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // extremes of code and cold junction, every channel, full cj patterns
      for (int ch = 0; ch < 4; ch++) begin
         add_sample(ch, 0, 0);
         add_sample(ch, 4095, 0);
      end
      add_sample(0, 0, -10000);
      add_sample(1, 4095, 10000);
      add_sample(2, 0, -16384);
      add_sample(3, 4095, 16383);
      add_sample(0, 1000, 0);
      add_sample(1, 1001, 0);
      add_sample(2, 2048, 5000);
      add_sample(3, 700, -3000);
      add_sample(0, 2730, 21845);
      add_sample(1, 1365, -21846);
      wait_drained();

      // extreme calibration, gain of zero on one channel
      write_reg(0, 32767); write_reg(1, 32767);
      write_reg(2, 8192);  write_reg(3, -32768);
      write_reg(4, 0);     write_reg(5, 12345);
      write_reg(6, 32767); write_reg(7, -32768);
      add_random(150);
      wait_drained();

      write_reg(0, 8192);  write_reg(1, -32768);
      write_reg(2, 32767); write_reg(3, 32767);
      write_reg(4, 8192);  write_reg(5, 0);
      write_reg(6, 8192);  write_reg(7, 32767);
      add_random(150);
      wait_drained();

      for (int i = 0; i < 8; i++)
         write_reg(i, (i % 2 == 0) ? $urandom_range(8192, 32767) : $urandom_range(0, 65535));
      add_random(100);
      wait (pending_samples.size() < 20);
      idle_enable = 1'b0;
      add_random(100);
      wait_drained();

      if (fail_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
